// ===== design/pcfc_pkg.sv =====
// pcfc_pkg: shared types and constants of the parallel camera frame capture core.
// Used by the channel interfaces, pcfc_step, pcfc_out_buf and the top level.
// No dependencies.
package pcfc_pkg;

	localparam int FRAME_PIXELS = 19200;
	localparam int CNT_W        = 15;
	localparam int BYTE_W       = 8;
	localparam int PIX_W        = 2 * BYTE_W;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_WAIT_END,
		PH_WAIT_START,
		PH_BETWEEN,
		PH_LINE
	} phase_t;

	typedef struct packed {
		logic              start_capture;
		logic              vsync_level;
		logic              href_level;
		logic              pclk_level;
		logic [BYTE_W-1:0] data_byte;
	} sample_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_value;
		logic [CNT_W-1:0] pixel_index;
		logic             frame_end;
		logic [CNT_W-1:0] pixel_count;
		logic             overflow;
	} result_t;

	typedef struct packed {
		phase_t            phase;
		logic              armed;
		logic              low_next;
		logic [BYTE_W-1:0] held;
		logic [CNT_W-1:0]  count;
		logic              ovf;
	} state_t;

endpackage

// ===== design/pcfc_if.sv =====
// Channel interfaces of the frame capture core: pin samples in, results out.
// Depends on pcfc_pkg for field widths.
interface pcfc_sample_if;
	logic                          valid;
	logic                          ready;
	logic                          start_capture;
	logic                          vsync_level;
	logic                          href_level;
	logic                          pclk_level;
	logic [pcfc_pkg::BYTE_W-1:0]   data_byte;

	modport source (output valid, start_capture, vsync_level, href_level, pclk_level,
		data_byte, input ready);
	modport sink (input valid, start_capture, vsync_level, href_level, pclk_level,
		data_byte, output ready);
endinterface

interface pcfc_result_if;
	logic                          valid;
	logic                          ready;
	logic [pcfc_pkg::PIX_W-1:0]    pixel_value;
	logic [pcfc_pkg::CNT_W-1:0]    pixel_index;
	logic                          frame_end;
	logic [pcfc_pkg::CNT_W-1:0]    pixel_count;
	logic                          overflow;

	modport source (output valid, pixel_value, pixel_index, frame_end, pixel_count,
		overflow, input ready);
	modport sink (input valid, pixel_value, pixel_index, frame_end, pixel_count,
		overflow, output ready);
endinterface

// ===== design/pcfc_step.sv =====
// pcfc_step: next capture state and optional result for one pin sample.
// Pure combinational; depends on pcfc_pkg.
module pcfc_step (
	input  pcfc_pkg::state_t  cur,
	input  pcfc_pkg::sample_t smp,
	output pcfc_pkg::state_t  nxt,
	output logic              res_valid,
	output pcfc_pkg::result_t res
);

	logic go;

	always_comb begin
		nxt       = cur;
		res_valid = 1'b0;
		res       = '0;
		go        = 1'b1;

		// phases may advance several steps within one sample
		if (nxt.phase == pcfc_pkg::PH_IDLE) begin
			if (!smp.start_capture) begin
				go = 1'b0;
			end else begin
				nxt.phase    = pcfc_pkg::PH_WAIT_END;
				nxt.count    = '0;
				nxt.ovf      = 1'b0;
				nxt.low_next = 1'b0;
				nxt.held     = '0;
				nxt.armed    = 1'b1;
			end
		end

		if (go && nxt.phase == pcfc_pkg::PH_WAIT_END) begin
			if (smp.vsync_level) begin
				go = 1'b0;
			end else begin
				nxt.phase = pcfc_pkg::PH_WAIT_START;
			end
		end

		if (go && nxt.phase == pcfc_pkg::PH_WAIT_START) begin
			if (!smp.vsync_level) begin
				go = 1'b0;
			end else begin
				nxt.phase = pcfc_pkg::PH_BETWEEN;
			end
		end

		if (go && nxt.phase == pcfc_pkg::PH_BETWEEN) begin
			if (!smp.vsync_level) begin
				nxt.phase       = pcfc_pkg::PH_IDLE;
				res_valid       = 1'b1;
				res.frame_end   = 1'b1;
				res.pixel_count = nxt.count;
				res.overflow    = nxt.ovf;
				go              = 1'b0;
			end else if (!smp.href_level) begin
				go = 1'b0;
			end else begin
				nxt.phase    = pcfc_pkg::PH_LINE;
				nxt.armed    = 1'b1;
				nxt.low_next = 1'b0;
			end
		end

		if (go && nxt.phase == pcfc_pkg::PH_LINE) begin
			if (!smp.pclk_level) begin
				nxt.armed = 1'b1;
			end
			if (!nxt.low_next) begin
				// href and vsync are looked at only between byte pairs
				if (nxt.armed) begin
					if (!smp.href_level) begin
						if (!smp.vsync_level) begin
							nxt.phase       = pcfc_pkg::PH_IDLE;
							res_valid       = 1'b1;
							res.frame_end   = 1'b1;
							res.pixel_count = nxt.count;
							res.overflow    = nxt.ovf;
						end else begin
							nxt.phase = pcfc_pkg::PH_BETWEEN;
						end
					end else if (smp.pclk_level) begin
						nxt.held     = smp.data_byte;
						nxt.low_next = 1'b1;
						nxt.armed    = 1'b0;
					end
				end
			end else if (smp.pclk_level && nxt.armed) begin
				nxt.low_next = 1'b0;
				nxt.armed    = 1'b0;
				if (nxt.count < pcfc_pkg::CNT_W'(pcfc_pkg::FRAME_PIXELS)) begin
					res_valid       = 1'b1;
					res.pixel_value = {nxt.held, smp.data_byte};
					res.pixel_index = nxt.count;
					nxt.count       = nxt.count + 1'b1;
				end else begin
					nxt.ovf = 1'b1;
				end
			end
		end
	end

endmodule

// ===== design/pcfc_out_buf.sv =====
// pcfc_out_buf: output register plus skid register for the result channel.
// Depends on pcfc_pkg and pcfc_result_if.
module pcfc_out_buf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  pcfc_pkg::result_t    push_data,
	output logic                 full,
	pcfc_result_if.source        result
);

	pcfc_pkg::result_t main_q;
	pcfc_pkg::result_t skid_q;
	logic              main_v_q;
	logic              skid_v_q;
	logic              pop;

	assign pop  = main_v_q & result.ready;
	assign full = skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop) begin
			// skid full means no push this cycle
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				main_v_q <= push;
			end
		end else if (push) begin
			if (!main_v_q) begin
				main_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			main_q <= skid_v_q ? skid_q : push_data;
		end else if (push) begin
			if (!main_v_q) begin
				main_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end
	end

	assign result.valid       = main_v_q;
	assign result.pixel_value = main_q.pixel_value;
	assign result.pixel_index = main_q.pixel_index;
	assign result.frame_end   = main_q.frame_end;
	assign result.pixel_count = main_q.pixel_count;
	assign result.overflow    = main_q.overflow;

endmodule

// ===== design/parallel_camera_frame_capture_core.sv =====
// Channel  | Dir | Payload                                              | Transfer
// sample   | in  | start_capture, vsync/href/pclk levels, data_byte     | valid & ready
// result   | out | pixel_value, pixel_index, frame_end, pixel_count, ovf | valid & ready
//
// One pin sample per cycle while sample.ready is high; the capture state updates in the cycle of the transfer.
// A result is registered into the output register, or into the skid register while the output register is full.
// Output register plus skid register: sample.ready drops only while both hold results.
// Reset (arst_n low) returns to idle, pixel clock armed, counter and flags cleared.
// Depends on pcfc_pkg, pcfc_if, pcfc_step and pcfc_out_buf.
module parallel_camera_frame_capture_core (
	input  logic          clk,
	input  logic          arst_n,
	pcfc_sample_if.sink   sample,
	pcfc_result_if.source result
);

	pcfc_pkg::state_t  state_q;
	pcfc_pkg::state_t  state_nxt;
	pcfc_pkg::sample_t smp;
	pcfc_pkg::result_t res;
	logic              res_valid;
	logic              buf_full;
	logic              accept;

	assign smp.start_capture = sample.start_capture;
	assign smp.vsync_level   = sample.vsync_level;
	assign smp.href_level    = sample.href_level;
	assign smp.pclk_level    = sample.pclk_level;
	assign smp.data_byte     = sample.data_byte;

	assign sample.ready = ~buf_full;
	assign accept       = sample.valid & ~buf_full;

	pcfc_step u_step (
		.cur       (state_q),
		.smp       (smp),
		.nxt       (state_nxt),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase    <= pcfc_pkg::PH_IDLE;
			state_q.armed    <= 1'b1;
			state_q.low_next <= 1'b0;
			state_q.held     <= '0;
			state_q.count    <= '0;
			state_q.ovf      <= 1'b0;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	pcfc_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept & res_valid),
		.push_data (res),
		.full      (buf_full),
		.result    (result)
	);

endmodule
